>>> rtl/smac_pkg.sv
// Shared types and codes for the shadow memory access checker.
// No dependencies; the front end, back end, top level and testbench import it.
package smac_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_CHECK    = 2'd0,
    OP_POISON   = 2'd1,
    OP_UNPOISON = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_VIOLATION = 2'd1,
    ST_ERROR     = 2'd2
  } status_t;

  // How the back end carries out a classified request
  typedef enum logic [1:0] {
    CK_DONE  = 2'd0,  // result known up front, no shadow access
    CK_CHECK = 2'd1,  // walk shadow bytes and test them
    CK_FILL  = 2'd2   // write a run of shadow bytes
  } cmd_kind_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR = 2'd0,
    BK_IDLE  = 2'd1,
    BK_CHECK = 2'd2,
    BK_FILL  = 2'd3
  } bk_state_t;

  // One result transaction
  typedef struct packed {
    status_t     status;
    logic [15:0] fault;
  } res_t;

endpackage

>>> rtl/smac_fifo.sv
// Small register queue used between the front end, back end and result port.
// Generic over the entry type; no package dependencies.
module smac_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  T                entry_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push;
  logic            do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/smac_front.sv
// Front end: holds the check_enable register and classifies each request.
// Uses smac_pkg; the command type is handed down from the top level.
module smac_front import smac_pkg::*; #(
  parameter int  ADDR_BITS     = 16,
  parameter int  GRANULE_SHIFT = 3,
  parameter type cmd_t         = logic
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_check_enable,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_address,
  input  logic [15:0]       in_access_size,
  input  logic signed [7:0] in_poison_value,
  output cmd_t              cmd
);

  localparam int IW = ADDR_BITS - GRANULE_SHIFT;
  localparam int AW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam int EW = AW + 1;
  localparam int CW = IW + 1;
  localparam logic [EW-1:0] REGION = EW'(1) << ADDR_BITS;
  localparam logic [AW-1:0] AMASK  = AW'(REGION - EW'(1));

  logic                     check_en_r;
  logic [AW-1:0]            addr_m;
  logic [EW-1:0]            end_a;
  logic                     past_end;
  logic                     addr_mis;
  logic                     size_mis;
  logic [15:0]              size_g;
  logic [CW-1:0]            cnt_unp;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_en_r <= 1'b1;
    end else if (cfg_valid) begin
      check_en_r <= cfg_check_enable;
    end
  end

  // address arithmetic shared by all opcodes
  assign addr_m   = AW'(in_address) & AMASK;
  assign end_a    = EW'(addr_m) + EW'(in_access_size);
  assign past_end = (end_a > REGION);
  assign addr_mis = |addr_m[GRANULE_SHIFT-1:0];
  assign size_mis = |in_access_size[GRANULE_SHIFT-1:0];
  assign size_g   = in_access_size >> GRANULE_SHIFT;
  assign cnt_unp  = CW'(size_g) + CW'(size_mis);

  // classification
  always_comb begin
    cmd         = '0;
    cmd.kind    = CK_DONE;
    cmd.status  = ST_ERROR;
    cmd.latch   = 1'b0;
    cmd.fault   = addr_m[15:0];
    cmd.first_g = addr_m[GRANULE_SHIFT +: IW];
    cmd.end_a   = end_a;
    cmd.cnt     = CW'(size_g);
    cmd.val     = in_poison_value;
    cmd.part_en = 1'b0;
    cmd.part    = 8'(in_access_size[GRANULE_SHIFT-1:0]);
    unique case (op_t'(in_opcode))
      OP_CHECK: begin
        if (!check_en_r || in_access_size == '0) begin
          cmd.status = ST_OK;
        end else if (past_end) begin
          cmd.latch = 1'b1;
        end else begin
          cmd.kind   = CK_CHECK;
          cmd.status = ST_OK;
        end
      end
      OP_POISON: begin
        if (addr_mis || size_mis || past_end) begin
          cmd.status = ST_ERROR;
        end else if (size_g == '0) begin
          cmd.status = ST_OK;
        end else begin
          cmd.kind   = CK_FILL;
          cmd.status = ST_OK;
        end
      end
      OP_UNPOISON: begin
        cmd.val     = '0;
        cmd.part_en = size_mis;
        cmd.cnt     = cnt_unp;
        if (addr_mis || past_end) begin
          cmd.status = ST_ERROR;
        end else if (cnt_unp == '0) begin
          cmd.status = ST_OK;
        end else begin
          cmd.kind   = CK_FILL;
          cmd.status = ST_OK;
        end
      end
      default: begin
        cmd.status = ST_ERROR;
      end
    endcase
  end

endmodule

>>> rtl/smac_back.sv
// Back end: shadow memory, clearing pass after reset, check walk and fills.
// Uses smac_pkg; takes classified commands and produces result transactions.
module smac_back import smac_pkg::*; #(
  parameter int  ADDR_BITS     = 16,
  parameter int  GRANULE_SHIFT = 3,
  parameter type cmd_t         = logic
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res,
  output logic clear_done
);

  localparam int IW = ADDR_BITS - GRANULE_SHIFT;
  localparam int AW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam int EW = AW + 1;
  localparam int CW = IW + 1;

  logic [7:0]               shadow_mem [2**IW];

  bk_state_t                state_r;
  bk_state_t                state_nxt;
  logic [IW-1:0]            clr_idx_r;
  logic [IW-1:0]            g_r;
  logic [IW-1:0]            g_nxt;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            cnt_nxt;
  logic                     issued_r;
  logic                     issued_nxt;
  logic                     rd_vld_r;
  logic                     rd_vld_nxt;
  logic                     rd_last_r;
  logic                     rd_last_nxt;
  logic [7:0]               rd_data_r;
  logic [15:0]              last_fault_r;
  logic [15:0]              last_fault_nxt;

  // fields held for the command in progress
  logic [IW-1:0]            last_g_r;
  logic [GRANULE_SHIFT-1:0] off_r;
  logic [7:0]               val_r;
  logic [7:0]               part_r;
  logic                     part_en_r;
  logic [15:0]              fault_r;

  logic                     start;
  logic                     load;
  logic [EW-1:0]            cmd_last;
  logic [IW-1:0]            cmd_last_g;
  logic                     tail_bad;
  logic                     chk_fail;
  logic                     chk_end;

  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic [7:0]               mem_wdata;
  logic                     mem_re;
  logic [IW-1:0]            mem_raddr;

  assign clear_done = (state_r != BK_CLEAR);
  assign start      = !cmd_empty && !res_full;
  assign load       = (state_r == BK_IDLE) && start;
  assign cmd_last   = cmd.end_a - EW'(1);
  assign cmd_last_g = cmd_last[GRANULE_SHIFT +: IW];

  // shadow byte test: inner granules must be zero, the last one covers the offset
  assign tail_bad = (rd_data_r != 8'd0) &&
                    ($signed({1'b0, 8'(off_r)}) >= $signed({rd_data_r[7], rd_data_r}));
  assign chk_fail = rd_last_r ? tail_bad : (rd_data_r != 8'd0);
  assign chk_end  = rd_vld_r && (rd_last_r || rd_data_r != 8'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: begin
        if (clr_idx_r == '1) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (start) begin
          unique case (cmd.kind)
            CK_CHECK: state_nxt = BK_CHECK;
            CK_FILL:  state_nxt = BK_FILL;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_CHECK: begin
        if (chk_end) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_FILL: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs, memory port and datapath updates
  always_comb begin
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res.status     = ST_OK;
    res.fault      = last_fault_r;
    mem_we         = 1'b0;
    mem_waddr      = g_r;
    mem_wdata      = val_r;
    mem_re         = 1'b0;
    mem_raddr      = g_r;
    g_nxt          = g_r;
    cnt_nxt        = cnt_r;
    issued_nxt     = issued_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = rd_last_r;
    last_fault_nxt = last_fault_r;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
      end
      BK_IDLE: begin
        if (start) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CK_CHECK: begin
              // first read goes out while the command is loaded
              mem_re      = 1'b1;
              mem_raddr   = cmd.first_g;
              rd_vld_nxt  = 1'b1;
              rd_last_nxt = (cmd.first_g == cmd_last_g);
              issued_nxt  = (cmd.first_g == cmd_last_g);
              g_nxt       = cmd.first_g + 1'b1;
            end
            CK_FILL: begin
              g_nxt   = cmd.first_g;
              cnt_nxt = cmd.cnt;
            end
            default: begin
              res_push   = 1'b1;
              res.status = cmd.status;
              if (cmd.latch) begin
                last_fault_nxt = cmd.fault;
                res.fault      = cmd.fault;
              end
            end
          endcase
        end
      end
      BK_CHECK: begin
        if (chk_end) begin
          res_push = 1'b1;
          if (chk_fail) begin
            res.status     = ST_VIOLATION;
            res.fault      = fault_r;
            last_fault_nxt = fault_r;
          end
        end else if (!issued_r) begin
          mem_re      = 1'b1;
          mem_raddr   = g_r;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (g_r == last_g_r);
          issued_nxt  = (g_r == last_g_r);
          g_nxt       = g_r + 1'b1;
        end
      end
      BK_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = g_r;
        mem_wdata = (cnt_r == CW'(1) && part_en_r) ? part_r : val_r;
        g_nxt     = g_r + 1'b1;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          res_push = 1'b1;
        end
      end
      default: begin
        res_push = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_CLEAR;
      clr_idx_r    <= '0;
      rd_vld_r     <= 1'b0;
      last_fault_r <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_vld_r     <= rd_vld_nxt;
      last_fault_r <= last_fault_nxt;
      if (state_r == BK_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    g_r       <= g_nxt;
    cnt_r     <= cnt_nxt;
    issued_r  <= issued_nxt;
    rd_last_r <= rd_last_nxt;
    if (load) begin
      last_g_r  <= cmd_last_g;
      off_r     <= cmd_last[GRANULE_SHIFT-1:0];
      val_r     <= cmd.val;
      part_r    <= cmd.part;
      part_en_r <= cmd.part_en;
      fault_r   <= cmd.fault;
    end
  end

  // shadow memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= shadow_mem[mem_raddr];
    end
  end

endmodule

>>> rtl/shadow_memory_access_checker.sv
// Shadow memory access checker: one signed shadow byte per granule of memory.
// Requests enter through a queue-style port (in_push / in_full) with opcode,
// address, access_size and poison_value; each transaction yields exactly one
// result (status, fault_address) on a queue-style output (out_empty / out_pop).
// The cfg_ channel (valid/ready, ready always high) writes check_enable.
// After reset a clearing pass zeroes the shadow memory, one entry per cycle,
// all 2**(ADDR_BITS-GRANULE_SHIFT) entries (8192 by default); in_full stays high
// until it ends. Reset also clears the fault address and sets check_enable to 1.
// A request passes the command queue, the back end and the result queue before
// its result is visible. Requests settled by the front end (errors, disabled
// checks, empty regions) leave the back end without shadow access; a check or
// fill walks its granules one granule per cycle through the shadow memory, and
// the back end takes no new command until the walk is over.
// A two-entry command queue sits between front and back, and a two-entry
// result queue holds finished transactions; when out_pop stays low, results
// wait there, and once both queues fill in_full rises.
module shadow_memory_access_checker import smac_pkg::*; #(
  parameter int ADDR_BITS     = 16,
  parameter int GRANULE_SHIFT = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_check_enable,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_opcode,
  input  logic [15:0]       in_address,
  input  logic [15:0]       in_access_size,
  input  logic signed [7:0] in_poison_value,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [1:0]        out_status,
  output logic [15:0]       out_fault_address
);

  localparam int IW = ADDR_BITS - GRANULE_SHIFT;
  localparam int AW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam int EW = AW + 1;
  localparam int CW = IW + 1;

  // classified command passed from front to back
  typedef struct packed {
    cmd_kind_t     kind;
    status_t       status;
    logic          latch;
    logic [15:0]   fault;
    logic [IW-1:0] first_g;
    logic [EW-1:0] end_a;
    logic [CW-1:0] cnt;
    logic [7:0]    val;
    logic          part_en;
    logic [7:0]    part;
  } cmd_t;

  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_full;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;
  logic clear_done;

  assign in_full           = cmd_full || !clear_done;
  assign out_status        = res_out.status;
  assign out_fault_address = res_out.fault;

  smac_front #(
    .ADDR_BITS     (ADDR_BITS),
    .GRANULE_SHIFT (GRANULE_SHIFT),
    .cmd_t         (cmd_t)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_check_enable (cfg_check_enable),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_access_size   (in_access_size),
    .in_poison_value  (in_poison_value),
    .cmd              (cmd_in)
  );

  smac_fifo #(
    .T     (cmd_t),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  smac_back #(
    .ADDR_BITS     (ADDR_BITS),
    .GRANULE_SHIFT (GRANULE_SHIFT),
    .cmd_t         (cmd_t)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in),
    .clear_done (clear_done)
  );

  smac_fifo #(
    .T     (res_t),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

endmodule

>>> rtl/smac_checker.sv
// Port-level assertions for shadow_memory_access_checker, attached by bind.
// Sees only the top-level ports; no package dependencies.
module smac_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_status,
  input logic [15:0] out_fault_address
);

  // reset drains the result queue
  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("result queue not empty after reset");

  // clearing pass keeps the input closed for its first cycles
  a_rst_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_full ##1 in_full)
    else $error("request accepted during shadow clearing pass");

  // no transaction is accepted while the clearing pass has just started
  a_no_early_push: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) && in_push |-> in_full)
    else $error("request taken right after reset");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_status)
                               && $stable(out_fault_address))
    else $error("stalled result changed");

endmodule

bind shadow_memory_access_checker smac_checker u_smac_checker (.*);

>>> dv/tb_top.sv
// Self-checking testbench for shadow_memory_access_checker.
// Depends on smac_pkg and the block's RTL; it carries its own shadow-store predictor.
`timescale 1ns / 1ps

module tb_top;
  import smac_pkg::*;

  localparam int GRAN_SHIFT   = 3;
  localparam int GRAN_BYTES   = 1 << GRAN_SHIFT;
  localparam int REGION_BYTES = 1 << 16;
  localparam int SHADOW_DEPTH = REGION_BYTES >> GRAN_SHIFT;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int LONG_HOLD    = 100;
  localparam int N_DIRECTED   = 27;
  localparam int N_PHASES     = 5;
  localparam int PHASE_ITEMS  = 85;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One directed stimulus row; status/fault are used only when known is set
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [15:0] size;
    logic [7:0]  pv;
    bit          known;
    logic [1:0]  status;
    logic [15:0] fault;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_check_enable;
  logic              in_push;
  logic              in_full;
  logic [1:0]        in_opcode;
  logic [15:0]       in_address;
  logic [15:0]       in_access_size;
  logic signed [7:0] in_poison_value;
  logic              out_empty;
  logic              out_pop;
  logic [1:0]        out_status;
  logic [15:0]       out_fault_address;

  // Predictor state
  logic signed [7:0] shadow_mirror [SHADOW_DEPTH];
  logic [15:0]       fault_mirror;
  bit                enable_mirror;

  res_t expected_results [$];

  int  cycle_count;
  int  errors;
  int  items_sent;
  int  full_stalls;
  int  long_holds;
  int  op_counts [4];
  int  status_counts [4];
  bit  idle_on;
  bit  long_hold_req;
  logic [15:0] window_base;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // fresh state, region extremes, unused opcode, malformed fills
    '{OP_CHECK,    16'h0000, 16'd1,     8'h00, 1'b1, ST_OK,        16'h0000},
    '{OP_CHECK,    16'hFFFF, 16'd1,     8'h00, 1'b1, ST_OK,        16'h0000},
    '{OP_CHECK,    16'hFFFF, 16'd2,     8'h00, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_CHECK,    16'h0000, 16'd0,     8'h00, 1'b1, ST_OK,        16'hFFFF},
    '{OP_UNUSED,   16'h1234, 16'd8,     8'h00, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_POISON,   16'h0003, 16'd8,     8'hFF, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_POISON,   16'h0008, 16'd5,     8'hFF, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_POISON,   16'hFFF8, 16'd16,    8'hFF, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_UNPOISON, 16'h0001, 16'd8,     8'h00, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_UNPOISON, 16'hFFF8, 16'd9,     8'h00, 1'b1, ST_ERROR,     16'hFFFF},
    '{OP_POISON,   16'h0100, 16'd16,    8'h80, 1'b1, ST_OK,        16'hFFFF},
    '{OP_CHECK,    16'h0100, 16'd1,     8'h00, 1'b1, ST_VIOLATION, 16'h0100},
    // straddling accesses and partial granules
    '{OP_CHECK,    16'h00FE, 16'd2,     8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_UNPOISON, 16'h0100, 16'd11,    8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'h0108, 16'd3,     8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'h0108, 16'd4,     8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'h0100, 16'd12,    8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_POISON,   16'h0000, 16'd0,     8'h7F, 1'b0, ST_OK,        16'h0000},
    '{OP_UNPOISON, 16'h0203, 16'd0,     8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_POISON,   16'h0200, 16'd8,     8'h7F, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'h01F8, 16'd16,    8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'h0200, 16'd9,     8'h00, 1'b0, ST_OK,        16'h0000},
    // whole-region fills and walks
    '{OP_POISON,   16'h0000, 16'hFFF8,  8'h85, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'h0000, 16'hFFFF,  8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_UNPOISON, 16'h0000, 16'hFFFF,  8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'hFFF8, 16'd8,     8'h00, 1'b0, ST_OK,        16'h0000},
    '{OP_CHECK,    16'hFFF8, 16'd7,     8'h00, 1'b0, ST_OK,        16'h0000}
  };

  bit enable_plan [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  shadow_memory_access_checker #(
    .ADDR_BITS    (16),
    .GRANULE_SHIFT(GRAN_SHIFT)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_check_enable (cfg_check_enable),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_opcode        (in_opcode),
    .in_address       (in_address),
    .in_access_size   (in_access_size),
    .in_poison_value  (in_poison_value),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_fault_address(out_fault_address)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    if (errors <= 60)
      $display("MISMATCH cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // Expected outcome of one request; updates the shadow mirror and fault latch
  function automatic res_t predict_request(input logic [1:0] op, input logic [15:0] addr,
                                           input logic [15:0] size, input logic [7:0] pv);
    res_t              outcome;
    int                first_g, last_g, last_byte, end_byte, g, len;
    logic signed [7:0] tail;
    bit                hit;
    outcome.status = ST_OK;
    end_byte = int'(addr) + int'(size);
    first_g  = int'(addr) >> GRAN_SHIFT;
    len      = int'(size) >> GRAN_SHIFT;
    case (op)
      OP_CHECK: begin
        if (enable_mirror && size != 0) begin
          if (end_byte > REGION_BYTES) begin
            outcome.status = ST_ERROR;
            fault_mirror = addr;
          end else begin
            last_byte = end_byte - 1;
            last_g = last_byte >> GRAN_SHIFT;
            hit = 1'b0;
            for (g = first_g; g < last_g; g++)
              if (shadow_mirror[g] != 0) hit = 1'b1;
            // last granule: partial count compared signed against the byte offset
            tail = shadow_mirror[last_g];
            if (tail != 0 && (last_byte % GRAN_BYTES) >= int'(tail)) hit = 1'b1;
            if (hit) begin
              outcome.status = ST_VIOLATION;
              fault_mirror = addr;
            end
          end
        end
      end
      OP_POISON: begin
        if ((addr % GRAN_BYTES) != 0 || (size % GRAN_BYTES) != 0 || end_byte > REGION_BYTES)
          outcome.status = ST_ERROR;
        else
          for (g = first_g; g < first_g + len; g++) shadow_mirror[g] = pv;
      end
      OP_UNPOISON: begin
        if ((addr % GRAN_BYTES) != 0 || end_byte > REGION_BYTES) begin
          outcome.status = ST_ERROR;
        end else begin
          for (g = first_g; g < first_g + len; g++) shadow_mirror[g] = 8'sd0;
          if ((size % GRAN_BYTES) != 0) shadow_mirror[first_g + len] = 8'(size % GRAN_BYTES);
        end
      end
      default: outcome.status = ST_ERROR;
    endcase
    outcome.fault = fault_mirror;
    return outcome;
  endfunction

  // Offer one request, wait for the push to land, queue its expected result
  task automatic offer_request(input logic [1:0] op, input logic [15:0] addr,
                               input logic [15:0] size, input logic [7:0] pv,
                               input bit known, input res_t typed);
    res_t want;
    int   gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push         <= 1'b1;
    in_opcode       <= op;
    in_address      <= addr;
    in_access_size  <= size;
    in_poison_value <= pv;
    do begin
      @(posedge clk);
      if (in_full && items_sent > 0) full_stalls++;
    end while (in_full);
    want = predict_request(op, addr, size, pv);
    if (known) want = typed;
    expected_results.push_back(want);
    items_sent++;
    op_counts[op]++;
  endtask

  // Sender pause: stop pushing until every pending result is back
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_check_enable(input bit en);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_check_enable <= en;
    do @(posedge clk); while (!cfg_ready);
    enable_mirror = en;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random request, mostly well-formed traffic around a small window
  task automatic pick_random_request(output logic [1:0] op, output logic [15:0] addr,
                                     output logic [15:0] size, output logic [7:0] pv);
    int r, k;
    r    = $urandom_range(0, 99);
    k    = $urandom_range(0, 99);
    pv   = 8'($urandom);
    op   = OP_CHECK;
    addr = 16'($urandom);
    size = 16'($urandom);
    if (r < 45) begin
      addr = 16'(window_base + $urandom_range(0, 511));
      if (k < 5)       size = 16'd0;
      else if (k < 65) size = 16'($urandom_range(1, 8));
      else if (k < 90) size = 16'($urandom_range(9, 40));
      else             size = 16'($urandom_range(41, 256));
    end else if (r < 63) begin
      op   = OP_POISON;
      addr = 16'(window_base + GRAN_BYTES * $urandom_range(0, 63));
      size = 16'(GRAN_BYTES * $urandom_range(0, 6));
      if (k < 40)      pv = 8'($urandom_range(128, 255));
      else if (k < 70) pv = 8'($urandom_range(1, GRAN_BYTES - 1));
      else if (k < 80) pv = 8'h00;
    end else if (r < 80) begin
      op   = OP_UNPOISON;
      addr = 16'(window_base + GRAN_BYTES * $urandom_range(0, 63));
      size = 16'($urandom_range(0, 60));
    end else if (r < 87) begin
      // full-range fields; about half run past the end of the region
      op = 2'($urandom_range(0, 2));
    end else if (r < 93) begin
      // noise: unused opcode or misaligned fills
      if (k < 34) begin
        op = OP_UNUSED;
      end else begin
        op   = (k < 67) ? OP_POISON : OP_UNPOISON;
        addr = 16'(window_base + GRAN_BYTES * $urandom_range(0, 63) + $urandom_range(1, 7));
        size = 16'($urandom_range(0, 64));
      end
    end else begin
      // requests at the top of the region, some crossing its end
      op   = 2'($urandom_range(0, 2));
      addr = 16'(16'hFFFF - $urandom_range(0, 63));
      if (k < 50) addr = addr & ~16'(GRAN_BYTES - 1);
      size = 16'($urandom_range(0, 80));
    end
  endtask

  // Result side: random pop bursts plus the requested long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
        long_holds++;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Result monitor: compare each popped transaction with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1 && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 16'(out_status), 16'h0);
      end else begin
        want = expected_results.pop_front();
        status_counts[out_status]++;
        if (out_status !== want.status)
          report_mismatch("status", 16'(out_status), 16'(want.status));
        if (out_fault_address !== want.fault)
          report_mismatch("fault_address", out_fault_address, want.fault);
      end
    end
  end

  // Stimulus
  initial begin
    logic [1:0]  op;
    logic [15:0] addr, size;
    logic [7:0]  pv;
    res_t        typed;
    int          ph, i;

    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_check_enable = 1'b0;
    in_push          = 1'b0;
    in_opcode        = OP_CHECK;
    in_address       = '0;
    in_access_size   = '0;
    in_poison_value  = '0;
    out_pop          = 1'b0;
    idle_on          = 1'b1;
    long_hold_req    = 1'b0;
    window_base      = '0;
    for (i = 0; i < SHADOW_DEPTH; i++) shadow_mirror[i] = 8'sd0;
    fault_mirror  = '0;
    enable_mirror = 1'b1;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    set_check_enable(1'b1);

    // Directed table
    for (i = 0; i < N_DIRECTED; i++) begin
      typed.status = status_t'(directed_rows[i].status);
      typed.fault  = directed_rows[i].fault;
      offer_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].size,
                    directed_rows[i].pv, directed_rows[i].known, typed);
    end
    drain_results();

    // Random phases, one check_enable setting each; the last runs without idling
    for (ph = 0; ph < N_PHASES; ph++) begin
      repeat (4) @(posedge clk);
      set_check_enable(enable_plan[ph]);
      idle_on     = (ph != N_PHASES - 1);
      window_base = 16'(GRAN_BYTES * $urandom_range(0, SHADOW_DEPTH - 100));
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 1 && i == 20) long_hold_req = 1'b1;
        pick_random_request(op, addr, size, pv);
        offer_request(op, addr, size, pv, 1'b0, typed);
      end
      drain_results();
    end

    // Catch any stray result after the last one
    repeat (20) @(posedge clk);

    $display("Sent %0d requests: %0d checks, %0d poison, %0d unpoison, %0d unused opcode,",
             items_sent, op_counts[OP_CHECK], op_counts[OP_POISON],
             op_counts[OP_UNPOISON], op_counts[OP_UNUSED]);
    $display("seen %0d ok / %0d violation / %0d error; input blocked %0d cycles, %0d holds",
             status_counts[ST_OK], status_counts[ST_VIOLATION], status_counts[ST_ERROR],
             full_stalls, long_holds);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/smac_pkg.sv
rtl/smac_fifo.sv
rtl/smac_front.sv
rtl/smac_back.sv
rtl/shadow_memory_access_checker.sv
rtl/smac_checker.sv
dv/tb_top.sv
